// ===== src/odc_pkg.sv =====
// shared types, constants and tap table of the octave decimator cascade
`default_nettype none
package odc_pkg;

   // fixed filter and number formats
   localparam int TAPS        = 39;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 18;
   localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS    = 40;
   localparam int FILL_BITS   = 6;
   localparam int MASK_BITS   = 7;
   localparam int OCT_BITS    = 3;
   localparam int COUNT_BITS  = 3;
   localparam int MAX_RESULTS = 7;
   localparam int ROUND_SHIFT = 17;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MAC,
      ST_EMIT
   } odc_state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic skip_clr;
      logic write;
      logic mac_start;
      logic advance;
   } odc_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;
      logic full;
      logic mac_done;
      logic emit_ok;
      logic last_stage;
   } odc_stat_type;

   // symmetric lowpass taps, q1.17
   function automatic logic signed [COEF_BITS-1:0] coef(input logic [FILL_BITS-1:0] idx);
      logic signed [COEF_BITS-1:0] c;
      case (idx)
         6'd0, 6'd38:  c = 18'sd8;
         6'd1, 6'd37:  c = -18'sd26;
         6'd2, 6'd36:  c = -18'sd186;
         6'd3, 6'd35:  c = -18'sd297;
         6'd4, 6'd34:  c = 18'sd44;
         6'd5, 6'd33:  c = 18'sd564;
         6'd6, 6'd32:  c = 18'sd164;
         6'd7, 6'd31:  c = -18'sd997;
         6'd8, 6'd30:  c = -18'sd662;
         6'd9, 6'd29:  c = 18'sd1537;
         6'd10, 6'd28: c = 18'sd1607;
         6'd11, 6'd27: c = -18'sd2134;
         6'd12, 6'd26: c = -18'sd3259;
         6'd13, 6'd25: c = 18'sd2719;
         6'd14, 6'd24: c = 18'sd6204;
         6'd15, 6'd23: c = -18'sd3212;
         6'd16, 6'd22: c = -18'sd12530;
         6'd17, 6'd21: c = 18'sd3543;
         6'd18, 6'd20: c = 18'sd41246;
         6'd19:        c = 18'sd61877;
         default:      c = '0;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== src/octave_decimator_cascade.sv =====
// top level of the octave decimator cascade
//
// Input channel req_*: one audio sample per item (q1.15 in tdata), tuser set
// clears every stage history and reloads the per-stage skip flags from
// phase_mask before the sample is taken. Result channel rsp_*: zero to seven
// decimated samples per item, each tagged with the stage that made it, tlast
// on the final result of the item. Configuration channel csr_*: phase_mask,
// always ready, taking effect at the next block start.
// An item that no stage filters passes only through the idle and check
// states. Each stage that produces a result stores the sample, runs the
// single shared multiply-accumulate reading the history memory one tap a
// cycle, drains the read, multiply and accumulate registers and hands the
// result over. After the last stage hands over, the block returns straight
// to idle. The stage tagged octave k produces once every 2^k items.
// Reset clears the fill counts, skip flags and phase_mask; no clearing pass
// runs over the history memory. A result waits in the output register while
// the next item is accepted; a stalled receiver only halts the block when a
// further result needs that register.
`default_nettype none
module octave_decimator_cascade #(
   parameter int NUM_OCTAVES = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample
   input  wire logic        req_tuser,   // [0] block_start
   // result items
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [2:0] octave, [18:3] value, [23:19] zero
   output logic             rsp_tlast,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [6:0]  csr_data     // phase_mask
);
   import odc_pkg::*;

   localparam int NSTAGE = NUM_OCTAVES - 1;

   odc_cmd_type                   cmd;
   odc_stat_type                  stat;
   logic [OCT_BITS-1:0]           octave;
   logic signed [SAMPLE_BITS-1:0] value;

   assign csr_ready = 1'b1;

   // stage sequencer
   odc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // histories, mac and result register
   odc_datapath #(
      .NSTAGE (NSTAGE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_sample  (req_tdata[SAMPLE_BITS-1:0]),
      .in_start   (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_octave (octave),
      .rsp_value  (value),
      .rsp_last   (rsp_tlast)
   );

   // pack the result fields
   assign rsp_tdata = {5'b0, value, octave};

endmodule
`default_nettype wire

// ===== src/odc_ctrl.sv =====
// sequencer of the octave decimator cascade: walks the stages of one item
`default_nettype none
module odc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire odc_pkg::odc_stat_type stat,
   output odc_pkg::odc_cmd_type       cmd
);
   import odc_pkg::*;

   odc_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.skip) state_in = ST_IDLE;
            else if (stat.full) state_in = ST_MAC;
            else state_in = ST_IDLE;
         end
         ST_MAC: begin
            if (stat.mac_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.emit_ok) state_in = stat.last_stage ? ST_IDLE : ST_CHECK;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         ST_CHECK: begin
            cmd.skip_clr  = stat.skip;
            cmd.write     = !stat.skip;
            cmd.mac_start = !stat.skip && stat.full;
         end
         ST_MAC: begin
            cmd = '0;
         end
         ST_EMIT: begin
            cmd.advance = stat.emit_ok;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== src/odc_datapath.sv =====
// stage histories, per-stage counters, shared fir mac and result register
`default_nettype none
module odc_datapath #(
   parameter int NSTAGE = 7
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire odc_pkg::odc_cmd_type                    cmd,
   output odc_pkg::odc_stat_type                        stat,
   input  wire logic signed [odc_pkg::SAMPLE_BITS-1:0]  in_sample,
   input  wire logic                                    in_start,
   input  wire logic                                    csr_valid,
   input  wire logic [odc_pkg::MASK_BITS-1:0]           csr_data,
   input  wire logic                                    rsp_tready,
   output logic                                         rsp_valid,
   output logic [odc_pkg::OCT_BITS-1:0]                 rsp_octave,
   output logic signed [odc_pkg::SAMPLE_BITS-1:0]       rsp_value,
   output logic                                         rsp_last
);
   import odc_pkg::*;

   localparam int DEPTH = NSTAGE * TAPS;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = (NSTAGE > 1) ? $clog2(NSTAGE) : 1;

   localparam logic [FILL_BITS-1:0] TAP_LAST  = FILL_BITS'(TAPS - 1);
   localparam logic [FILL_BITS-1:0] FILL_KEEP = FILL_BITS'(TAPS - 2);
   localparam logic [COUNT_BITS-1:0] CNT_MAX  = COUNT_BITS'(MAX_RESULTS);
   localparam logic [COUNT_BITS-1:0] CNT_LAST = COUNT_BITS'(MAX_RESULTS - 1);

   // history memory, one circular window per stage
   logic signed [SAMPLE_BITS-1:0] hist_mem [DEPTH];

   // configuration and per-stage state
   logic [MASK_BITS-1:0]  mask_ff;
   logic [NSTAGE-1:0]     skip_ff;
   logic [FILL_BITS-1:0]  fill_ff [NSTAGE];
   logic [FILL_BITS-1:0]  ptr_ff  [NSTAGE];

   // walk through the stages of one item
   logic [SW-1:0]                 stage_ff;
   logic [AW-1:0]                 base_ff;
   logic [COUNT_BITS-1:0]         count_ff;
   logic signed [SAMPLE_BITS-1:0] x_ff;

   // mac pipeline
   logic                          issuing_ff, rd_vld_ff, prod_vld_ff;
   logic [FILL_BITS-1:0]          tap_ff, rd_ptr_ff, rd_tap_ff;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]    acc_ff;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [OCT_BITS-1:0]           rsp_octave_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_value_ff;
   logic                          rsp_last_ff;

   logic [15:0]                   mask_ext;
   logic [NSTAGE-1:0]             skip_load;
   logic [FILL_BITS-1:0]          cur_ptr, ptr_next, rd_ptr_next;
   logic [AW-1:0]                 wr_addr, rd_addr;
   logic [SW-1:0]                 nxt_stage;
   logic                          last_stage, next_emits, emit;
   logic signed [ACC_BITS-1:0]    rounded, quot;
   logic signed [SAMPLE_BITS-1:0] y;
   logic [4:0]                    oct_full;

   // skip flags reloaded at block start, stages past the mask never skip
   assign mask_ext  = 16'(mask_ff);
   assign skip_load = mask_ext[NSTAGE-1:0];

   // addressing
   assign cur_ptr     = ptr_ff[stage_ff];
   assign ptr_next    = (cur_ptr == TAP_LAST) ? '0 : cur_ptr + 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == TAP_LAST) ? '0 : rd_ptr_ff + 1'b1;
   assign wr_addr     = base_ff + AW'(cur_ptr);
   assign rd_addr     = base_ff + AW'(rd_ptr_ff);

   // round half up and saturate
   assign rounded = acc_ff + ACC_BITS'(65536);
   assign quot    = rounded >>> ROUND_SHIFT;
   always_comb begin
      if (quot > ACC_BITS'(32767)) y = 16'sh7FFF;
      else if (quot < -ACC_BITS'(32768)) y = 16'sh8000;
      else y = quot[SAMPLE_BITS-1:0];
   end

   // does the next stage produce a result within this item
   assign last_stage = (stage_ff == SW'(NSTAGE - 1));
   assign nxt_stage  = last_stage ? '0 : stage_ff + 1'b1;
   assign next_emits = !last_stage && !skip_ff[nxt_stage] && (fill_ff[nxt_stage] == TAP_LAST);
   assign emit       = cmd.advance && (count_ff != CNT_MAX);
   assign oct_full   = 5'(stage_ff) + 5'd1;

   assign stat.skip       = skip_ff[stage_ff];
   assign stat.full       = (fill_ff[stage_ff] == TAP_LAST);
   assign stat.mac_done   = !issuing_ff && !rd_vld_ff && !prod_vld_ff;
   assign stat.emit_ok    = (count_ff == CNT_MAX) || !rsp_valid_ff || rsp_tready;
   assign stat.last_stage = last_stage;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else if (csr_valid) begin
         mask_ff <= csr_data;
      end
   end

   // per-stage skip flags, fill counts and write pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff <= '0;
         for (int s = 0; s < NSTAGE; s++) begin
            fill_ff[s] <= '0;
            ptr_ff[s]  <= '0;
         end
      end else begin
         if (cmd.accept && in_start) begin
            skip_ff <= skip_load;
            for (int s = 0; s < NSTAGE; s++) fill_ff[s] <= '0;
         end
         if (cmd.skip_clr) skip_ff[stage_ff] <= 1'b0;
         if (cmd.write) begin
            ptr_ff[stage_ff]  <= ptr_next;
            fill_ff[stage_ff] <= stat.full ? FILL_KEEP : fill_ff[stage_ff] + 1'b1;
         end
      end
   end

   // stage walk control
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         base_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         stage_ff <= '0;
         base_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.advance) begin
         stage_ff <= stage_ff + 1'b1;
         base_ff  <= base_ff + AW'(TAPS);
         if (count_ff != CNT_MAX) count_ff <= count_ff + 1'b1;
      end
   end

   // stage input sample
   always_ff @(posedge clock) begin
      if (cmd.accept) x_ff <= in_sample;
      else if (cmd.advance) x_ff <= y;
   end

   // history memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.write) hist_mem[wr_addr] <= x_ff;
      rd_data_ff <= hist_mem[rd_addr];
   end

   // mac issue and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff  <= 1'b0;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
         tap_ff      <= '0;
      end else begin
         rd_vld_ff   <= issuing_ff;
         prod_vld_ff <= rd_vld_ff;
         if (cmd.mac_start) begin
            issuing_ff <= 1'b1;
            tap_ff     <= '0;
         end else if (issuing_ff) begin
            tap_ff <= tap_ff + 1'b1;
            if (tap_ff == TAP_LAST) issuing_ff <= 1'b0;
         end
      end
   end

   // mac datapath: read, multiply, accumulate
   assign prod_in = rd_data_ff * coef(rd_tap_ff);
   always_ff @(posedge clock) begin
      rd_tap_ff <= tap_ff;
      prod_ff   <= prod_in;
      if (cmd.mac_start) rd_ptr_ff <= ptr_next;
      else if (issuing_ff) rd_ptr_ff <= rd_ptr_next;
      if (cmd.mac_start) acc_ff <= '0;
      else if (prod_vld_ff) acc_ff <= acc_ff + ACC_BITS'(prod_ff);
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_octave_ff <= oct_full[OCT_BITS-1:0];
         rsp_value_ff  <= y;
         rsp_last_ff   <= (count_ff == CNT_LAST) || !next_emits;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_octave = rsp_octave_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

endmodule
`default_nettype wire
